FILE: design/gfpb_pkg.sv
package gfpb_pkg;

  // byte counter width, covers any frame length up to 31
  localparam int unsigned IDX_W = 5;

  // number of header bytes checked at the start of a frame
  localparam int unsigned HDR_LEN = 7;

  // byte positions of the little-endian rate words
  localparam logic [IDX_W-1:0] RATE_FIRST = 5'd16;
  localparam logic [IDX_W-1:0] RATE_LAST  = 5'd21;

  // reciprocal of three, scaled by 2^17, for magnitudes below 2^17
  localparam logic [15:0] RECIP3     = 16'd43691;
  localparam int unsigned RECIP3_SHIFT = 17;

  // calibration frames taken before measurement starts
  localparam logic [1:0] CAL_FRAMES = 2'd3;

  // result kind carried on the output user bits
  typedef enum logic [1:0] {
    ST_BAD_HDR = 2'd0,
    ST_CAL     = 2'd1,
    ST_MEAS    = 2'd2
  } status_t;

  // expected header byte at a given position
  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] val;
    case (pos)
      3'd0:    val = 8'hff;
      3'd1:    val = 8'hff;
      3'd2:    val = 8'h52;
      3'd3:    val = 8'h54;
      3'd4:    val = 8'h39;
      3'd5:    val = 8'h41;
      3'd6:    val = 8'h05;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

FILE: design/gyro_frame_parse_with_bias_core.sv
// Gyro frame parser: takes one serial byte per beat on the slave side (tuser set on the
// first byte of a frame) and gives one result beat on the master side for each frame,
// registered on the frame's last byte. Bytes 0..6 must match the header, bytes 16..21
// carry the x, y, z rates. A byte is taken every cycle unless a result waits unread;
// the per-byte work is one pass through the counter, header compare and capture logic.
// The first three good frames are calibration samples; the z bias derived from them
// goes through a three-stage divide-by-three pipeline (magnitude, quotient and sign
// registers) and is ready long before the next frame can end.
module gyro_frame_parse_with_bias_core #(
  parameter int unsigned FRAME_LEN = 27
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] rx_byte
  input  logic        s_tuser,  // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // [15:0] rate_x, [31:16] rate_y, [47:32] rate_z,
                                // [64:48] z_corrected, [71:65] zero
  output logic [1:0]  m_tuser   // [1:0] frame_status
);

  localparam int unsigned IW = gfpb_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_LEN - 1);

  // parser state
  logic [IW-1:0]      byte_index;
  logic               header_good;
  logic [7:0]         low_byte_hold;
  logic [15:0]        axis_capture [3];
  logic [1:0]         cal_count;
  logic signed [17:0] z_sum;
  logic               calibrated;

  // bias pipeline
  logic [16:0]        sum_abs;
  logic               sum_neg;
  logic [15:0]        quot;
  logic               quot_neg;
  logic signed [15:0] z_bias;
  logic [32:0]        prod;

  // result register
  logic               out_valid;
  logic [1:0]         out_status;
  logic [15:0]        out_x;
  logic [15:0]        out_y;
  logic [15:0]        out_z;
  logic [16:0]        out_zc;

  // per-byte decode
  logic               accept;
  logic [7:0]         rx_byte;
  logic [IW-1:0]      idx;
  logic               hdr_ok_next;
  logic               in_rates;
  logic [1:0]         axis_sel;
  logic [15:0]        cap_next [3];
  logic               last_byte;
  logic signed [15:0] z_now;
  logic signed [16:0] zc_now;
  logic [1:0]         cal_count_next;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign rx_byte  = s_tdata;

  // byte position, header check and rate capture
  always_comb begin
    idx = s_tuser ? '0 : byte_index;
    hdr_ok_next = s_tuser ? 1'b1 : header_good;
    if (idx < IW'(gfpb_pkg::HDR_LEN) && rx_byte != gfpb_pkg::hdr_byte(idx[2:0])) begin
      hdr_ok_next = 1'b0;
    end
    in_rates = idx >= gfpb_pkg::RATE_FIRST && idx <= gfpb_pkg::RATE_LAST;
    axis_sel = idx[2:1] - 2'd0;
    cap_next = axis_capture;
    if (in_rates && idx[0]) begin
      cap_next[axis_sel] = {rx_byte, low_byte_hold};
    end
    last_byte = idx == LAST_IDX;
    z_now = $signed(cap_next[2]);
    zc_now = 17'(z_now) - 17'(z_bias);
    cal_count_next = cal_count + 2'd1;
  end

  // parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      header_good   <= 1'b1;
      low_byte_hold <= '0;
      axis_capture  <= '{default: '0};
      cal_count     <= '0;
      z_sum         <= '0;
      calibrated    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // result beat loaded on a frame's last byte, cleared once read
      if (accept && last_byte) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        axis_capture <= cap_next;
        if (in_rates && !idx[0]) begin
          low_byte_hold <= rx_byte;
        end
        if (!last_byte) begin
          byte_index  <= idx + IW'(1);
          header_good <= hdr_ok_next;
        end else begin
          byte_index  <= '0;
          header_good <= 1'b1;
          if (hdr_ok_next && !calibrated) begin
            z_sum     <= z_sum + 18'(z_now);
            cal_count <= cal_count_next;
            if (cal_count_next == gfpb_pkg::CAL_FRAMES) begin
              calibrated <= 1'b1;
            end
          end
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      if (!hdr_ok_next) begin
        out_status <= gfpb_pkg::ST_BAD_HDR;
        out_x      <= '0;
        out_y      <= '0;
        out_z      <= '0;
        out_zc     <= '0;
      end else begin
        out_x <= cap_next[0];
        out_y <= cap_next[1];
        out_z <= cap_next[2];
        if (calibrated) begin
          out_status <= gfpb_pkg::ST_MEAS;
          out_zc     <= zc_now;
        end else begin
          out_status <= gfpb_pkg::ST_CAL;
          out_zc     <= '0;
        end
      end
    end
  end

  // bias = z_sum / 3 truncated toward zero: magnitude, reciprocal multiply, sign
  assign prod = 33'(sum_abs) * 33'(gfpb_pkg::RECIP3);

  always_ff @(posedge clk) begin
    sum_neg  <= z_sum[17];
    sum_abs  <= z_sum[17] ? 17'(-z_sum) : 17'(z_sum);
    quot     <= prod[gfpb_pkg::RECIP3_SHIFT +: 16];
    quot_neg <= sum_neg;
    z_bias   <= quot_neg ? $signed(-quot) : $signed(quot);
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {7'd0, out_zc, out_z, out_y, out_x};

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= LAST_IDX) else $error("byte index past frame end");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == gfpb_pkg::ST_BAD_HDR |-> m_tdata == '0)
    else $error("bad header result carries data");

  a_meas_cal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == gfpb_pkg::ST_MEAS |-> calibrated)
    else $error("measurement before calibration");

  a_cal_done: assert property (@(posedge clk) disable iff (rst)
    cal_count == gfpb_pkg::CAL_FRAMES |-> calibrated)
    else $error("calibration count full but not calibrated");
`endif

endmodule

FILE: dv/gyro_frame_parse_with_bias_core_test.sv
module gyro_frame_parse_with_bias_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LEN  = 27;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned HOLD_AT    = 500;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned RX_CALM_LO = 750;
  localparam int unsigned RX_CALM_HI = 950;
  localparam int unsigned RAND_BYTES = 950;

  // header bytes, byte 0 in the lowest bits
  localparam logic [55:0] SYNC_WORD = {8'h05, 8'h41, 8'h39, 8'h54, 8'h52, 8'hff, 8'hff};

  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BAD_HDR,
    FR_ABORT,
    FR_NO_START
  } frame_kind_t;

  typedef struct {
    logic [7:0]  data;
    logic        sof;
    logic        drain;
    int unsigned gap;
  } byte_beat_t;

  typedef struct {
    gfpb_pkg::status_t status;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [16:0] zc;
  } rate_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;  // [7:0] rx_byte
  logic        s_tuser = 1'b0;   // [0] frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;          // [15:0] x, [31:16] y, [47:32] z, [64:48] z_corrected
  logic [1:0]  m_tuser;          // [1:0] frame_status

  byte_beat_t   byte_feed[$];
  rate_result_t frames_due[$];

  // frame parser shadow state
  logic [4:0]  byte_pos   = '0;
  logic        hdr_ok     = 1'b1;
  logic [7:0]  lo_hold    = '0;
  logic [15:0] axis_word[3] = '{16'h0, 16'h0, 16'h0};
  logic [1:0]  cal_cnt    = '0;
  int          z_acc      = 0;
  int          z_off      = 0;
  logic        cal_done   = 1'b0;

  int unsigned bytes_sent = 0;
  int unsigned err_cnt    = 0;
  int unsigned n_bad      = 0;
  int unsigned n_cal      = 0;
  int unsigned n_meas     = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  logic        hold_done  = 1'b0;
  logic        tx_calm    = 1'b0;

  gyro_frame_parse_with_bias_core #(
    .FRAME_LEN(FRAME_LEN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // idle stretch length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // rate word with a bias toward the signed extremes
  function automatic logic [15:0] pick_rate();
    logic [15:0] edges[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h8001};
    if ($urandom_range(0, 99) < 15) return edges[$urandom_range(0, 5)];
    return 16'($urandom());
  endfunction

  // advance the shadow parser by one byte, queue the frame result if any
  task automatic parse_byte(input logic [7:0] b, input logic sof);
    rate_result_t res;
    int z;
    int zc;
    if (sof) begin
      byte_pos = '0;
      hdr_ok   = 1'b1;
    end
    if (byte_pos < gfpb_pkg::HDR_LEN && b != SYNC_WORD[int'(byte_pos)*8 +: 8]) hdr_ok = 1'b0;
    if (byte_pos >= 16 && byte_pos <= 21) begin
      if (!byte_pos[0]) lo_hold = b;
      else axis_word[(byte_pos - 17) >> 1] = {b, lo_hold};
    end
    if (byte_pos != 5'(FRAME_LEN - 1)) begin
      byte_pos = byte_pos + 5'd1;
      return;
    end
    byte_pos = '0;
    res = '{status: gfpb_pkg::ST_BAD_HDR, x: '0, y: '0, z: '0, zc: '0};
    if (!hdr_ok) begin
      hdr_ok = 1'b1;
      frames_due.push_back(res);
      return;
    end
    res.x = axis_word[0];
    res.y = axis_word[1];
    res.z = axis_word[2];
    z = int'($signed(axis_word[2]));
    if (!cal_done) begin
      z_acc   = z_acc + z;
      cal_cnt = cal_cnt + 2'd1;
      if (cal_cnt == 2'd3) begin
        z_off    = z_acc / 3;
        cal_done = 1'b1;
      end
      res.status = gfpb_pkg::ST_CAL;
    end else begin
      zc         = z - z_off;
      res.zc     = 17'(zc);
      res.status = gfpb_pkg::ST_MEAS;
    end
    frames_due.push_back(res);
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic sof, input logic drain);
    byte_beat_t bt;
    bt.data  = b;
    bt.sof   = sof;
    bt.drain = drain;
    bt.gap   = (tx_calm || $urandom_range(0, 99) < 70) ? 0 : idle_len();
    byte_feed.push_back(bt);
  endtask

  // one frame, possibly broken, rates placed at bytes 16..21
  task automatic send_frame(input frame_kind_t kind, input logic [15:0] rx,
                            input logic [15:0] ry, input logic [15:0] rz,
                            input logic drain);
    logic [47:0] rates;
    logic [7:0]  b;
    int unsigned cut;
    int unsigned bad_pos;
    rates   = {rz, ry, rx};
    cut     = (kind == FR_ABORT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
    bad_pos = $urandom_range(0, gfpb_pkg::HDR_LEN - 1);
    for (int i = 0; i < cut; i++) begin
      if (i < gfpb_pkg::HDR_LEN) b = SYNC_WORD[i*8 +: 8];
      else if (i >= 16 && i <= 21) b = rates[(i-16)*8 +: 8];
      else b = 8'($urandom_range(0, 255));
      if (kind == FR_BAD_HDR && i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      queue_byte(b, (i == 0) && (kind != FR_NO_START), drain && (i == 0));
    end
  endtask

  // byte driver
  always @(posedge clk) begin : drive_bytes
    byte_beat_t nb;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tuser);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (byte_feed.size() != 0 &&
                     !(byte_feed[0].drain && frames_due.size() != 0)) begin
          nb = byte_feed.pop_front();
          gap_left = nb.gap;
          s_tvalid <= 1'b1;
          s_tdata  <= nb.data;
          s_tuser  <= nb.sof;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver pacing, with one long hold-off
  always @(posedge clk) begin : pace_results
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && bytes_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!(bytes_sent >= RX_CALM_LO && bytes_sent < RX_CALM_HI) &&
                 $urandom_range(0, 99) < 25) begin
      stall_left = idle_len() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    rate_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      case (m_tuser)
        gfpb_pkg::ST_CAL:  n_cal++;
        gfpb_pkg::ST_MEAS: n_meas++;
        default: n_bad++;
      endcase
      if (frames_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: result with none expected: status %0d data %h",
                   $realtime, m_tuser, m_tdata);
      end else begin
        want = frames_due.pop_front();
        if (m_tuser != want.status || m_tdata[15:0] != want.x ||
            m_tdata[31:16] != want.y || m_tdata[47:32] != want.z ||
            m_tdata[64:48] != want.zc || m_tdata[71:65] != '0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: mismatch exp st %0d x %h y %h z %h zc %h",
                     $realtime, want.status, want.x, want.y, want.z, want.zc,
                     " / got st %0d x %h y %h z %h zc %h pad %h",
                     m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                     m_tdata[64:48], m_tdata[71:65]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("%0t: run did not finish, %0d results outstanding", $realtime,
               frames_due.size());
      $display("gyro_frame_parse_with_bias_core_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned r;
    frame_kind_t kind;
    int unsigned nframes;

    // directed: bad header, calibration with extreme z, abort, measurement, unflagged start
    send_frame(FR_BAD_HDR, pick_rate(), pick_rate(), pick_rate(), 1'b0);
    send_frame(FR_GOOD, 16'h7fff, 16'h8000, 16'h8000, 1'b0);
    send_frame(FR_ABORT, 16'h1234, 16'h5678, 16'h0100, 1'b0);
    send_frame(FR_GOOD, 16'h0000, 16'hffff, 16'h8000, 1'b0);
    send_frame(FR_GOOD, 16'h8000, 16'h7fff, 16'h8001, 1'b0);
    send_frame(FR_GOOD, 16'hffff, 16'h0001, 16'h7fff, 1'b0);
    send_frame(FR_GOOD, 16'h0001, 16'h0000, 16'h8000, 1'b0);
    send_frame(FR_NO_START, 16'h8001, 16'h7ffe, 16'h0000, 1'b0);
    send_frame(FR_BAD_HDR, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);

    // random frames, sender pauses for a full drain before the first and the thirty-first
    nframes = 0;
    kind = FR_GOOD;
    while (byte_feed.size() < RAND_BYTES) begin
      tx_calm = (nframes >= 20 && nframes < 26);
      r = $urandom_range(0, 99);
      if (r >= 95) begin
        repeat ($urandom_range(1, 10))
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b0);
        kind = FR_ABORT;
      end else begin
        if (r < 65) kind = FR_GOOD;
        else if (r < 77) kind = FR_BAD_HDR;
        else if (r < 87) kind = FR_ABORT;
        else kind = (kind == FR_ABORT) ? FR_GOOD : FR_NO_START;
        send_frame(kind, pick_rate(), pick_rate(), pick_rate(), nframes == 0 || nframes == 30);
        nframes++;
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (byte_feed.size() != 0 || s_tvalid || frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    err_cnt += frames_due.size();

    $display("sent %0d bytes; results: %0d calibration, %0d measurement, %0d bad header",
             bytes_sent, n_cal, n_meas, n_bad);
    $display("covered aborted and unflagged frames, random idles and a long output stall");
    if (err_cnt == 0) begin
      $display("gyro_frame_parse_with_bias_core_test: clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("gyro_frame_parse_with_bias_core_test: errors");
    end
    $finish;
  end

endmodule
